// ===== sv/msft_pkg.sv =====
// ----------------------------------------------------------------------------
// msft_pkg - shared types and constants of the field tokenizer
// Register indexes, reset values, field widths and separator helpers.
// ----------------------------------------------------------------------------
package msft_pkg;

	localparam int FIELD_W              = 12;
	localparam int SEP_W                = 18;
	localparam int SEP_REGS             = 4;
	localparam int CFG_IDX_W            = 3;
	localparam int NUM_SEPARATORS_DEF   = 4;
	localparam int MAX_SEPARATOR_LENGTH = 2;
	localparam int MAX_LINE_LENGTH      = 4096;

	// Longest separator the length code may select.
	localparam int LEN_CAP_I = (MAX_SEPARATOR_LENGTH < 2) ? MAX_SEPARATOR_LENGTH : 2;
	localparam logic [1:0] LEN_CAP = 2'(LEN_CAP_I);

	// Saturation point of byte positions and field start.
	localparam int POS_LIMIT_I = ((MAX_LINE_LENGTH - 1) < 4095) ? (MAX_LINE_LENGTH - 1) : 4095;
	localparam logic [FIELD_W-1:0] POS_LIMIT = FIELD_W'(POS_LIMIT_I);
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SEP_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_C    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE = 3'd4;

	// Reset patterns: tab and space, each one byte long.
	localparam logic [SEP_W-1:0] SEP_A_RST = 18'h10009;
	localparam logic [SEP_W-1:0] SEP_B_RST = 18'h10020;
	localparam logic [SEP_W-1:0] SEP_OFF   = 18'h00000;

	typedef logic [SEP_REGS-1:0][SEP_W-1:0] sep_bank_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] hit_len;
	} msft_hit_t;

	// Effective length of a separator pattern, capped.
	function automatic logic [1:0] sep_len(input logic [SEP_W-1:0] pat);
		logic [1:0] code;
		code = pat[17:16];
		return (code > LEN_CAP) ? LEN_CAP : code;
	endfunction

endpackage

// ===== sv/msft_match.sv =====
// ----------------------------------------------------------------------------
// msft_match - separator match tracker
// Holds one match position per separator and flags the first completion.
// ----------------------------------------------------------------------------
module msft_match
	import msft_pkg::*;
#(
	parameter int NUM_SEPARATORS = NUM_SEPARATORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       line_end,
	input  sep_bank_t  sep,
	output msft_hit_t  res
);

	logic [NUM_SEPARATORS-1:0] prog_q;
	logic [NUM_SEPARATORS-1:0] prog_nxt;
	logic [NUM_SEPARATORS-1:0] done;
	logic [1:0]                len [NUM_SEPARATORS];

	for (genvar i = 0; i < NUM_SEPARATORS; i++) begin : g_sep
		if (i < SEP_REGS) begin : g_reg
			logic       k;
			logic [7:0] want;
			logic       hit_byte;
			assign len[i]      = sep_len(sep[i]);
			// Take a stale position beyond the pattern as the start.
			assign k           = prog_q[i] && (len[i] > 2'd1);
			assign want        = k ? sep[i][15:8] : sep[i][7:0];
			assign hit_byte    = (len[i] != 2'd0) && (want == data_byte);
			assign done[i]     = hit_byte && ({1'b0, k} + 2'd1 == len[i]);
			assign prog_nxt[i] = hit_byte && !done[i];
		end else begin : g_off
			assign len[i]      = 2'd0;
			assign done[i]     = 1'b0;
			assign prog_nxt[i] = 1'b0;
		end
	end

	// Lowest index wins.
	always_comb begin
		res = '0;
		for (int i = NUM_SEPARATORS - 1; i >= 0; i--) begin
			if (done[i]) begin
				res.hit     = 1'b1;
				res.hit_len = len[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
		end else if (step) begin
			if (res.hit || line_end) begin
				prog_q <= '0;
			end else begin
				prog_q <= prog_nxt;
			end
		end
	end

	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.hit |=> prog_q == '0)
		else $error("match positions not cleared after a separator hit");

	a_hit_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> (res.hit_len != 2'd0 && res.hit_len <= LEN_CAP))
		else $error("separator hit with a bad length");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end |=> prog_q == '0)
		else $error("match positions survive a line end");

endmodule

// ===== sv/multi_separator_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_separator_field_tokenizer_unit - multi-separator field tokenizer
// Splits a byte stream into fields at up to four configurable separators.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one character per word in s_tdata[7:0]; s_tlast
//    marks the final byte of a line.
//  - Master stream emits one word per byte that reports a field or ends a
//    line (m_tlast high on a line's last byte, with the field count of the line).
//    m_tuser flags whether the word reports a field.
//  - Bytes that neither close a field nor end a line produce no word.
//  - An accepted byte passes the input register, then the result register.
//    Throughput: one byte per cycle unless the receiver stalls; the match
//    compare, the length arithmetic and the counter update all settle
//    between the input register and the result register.
//  - When the receiver stalls, the result register holds; the input stage
//    still takes one more byte, then s_tready drops until the result drains.
//  - Reset clears the line state and restores the default separators
//    (tab and space, collapsing on). Write configuration only while idle.
// ----------------------------------------------------------------------------
module multi_separator_field_tokenizer_unit
	import msft_pkg::*;
#(
	parameter int NUM_SEPARATORS = NUM_SEPARATORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEP_W-1:0]     cfg_data,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tlast,   // line_end
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [11:0] field_start, [23:12] field_length, [35:24] field_number,
	// [47:36] fields_in_line
	output logic [47:0]          m_tdata,
	output logic                 m_tuser,   // field_valid
	output logic                 m_tlast    // line_done
);

	// Configuration registers
	sep_bank_t sep_q;
	logic      collapse_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Line state
	logic [FIELD_W-1:0] pos_q;
	logic [FIELD_W-1:0] fstart_q;
	logic [FIELD_W-1:0] fcount_q;

	// Result register
	logic               out_valid_q;
	logic               fvalid_q;
	logic               done_q;
	logic [FIELD_W-1:0] fs_q;
	logic [FIELD_W-1:0] fl_q;
	logic [FIELD_W-1:0] fnum_q;
	logic [FIELD_W-1:0] fin_q;

	logic      advance;
	msft_hit_t hit;

	logic [FIELD_W:0]   next_pos;
	logic [FIELD_W:0]   match_start;
	logic [FIELD_W:0]   len_hit;
	logic [FIELD_W:0]   len_tail;
	logic [FIELD_W:0]   len_sel;
	logic               emit;
	logic [FIELD_W-1:0] fcount_nxt;
	logic [FIELD_W-1:0] next_sat;

	// Move the held byte forward when the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q[0]   <= SEP_A_RST;
			sep_q[1]   <= SEP_B_RST;
			sep_q[2]   <= SEP_OFF;
			sep_q[3]   <= SEP_OFF;
			collapse_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEP_A:    sep_q[0]   <= cfg_data;
				REG_SEP_B:    sep_q[1]   <= cfg_data;
				REG_SEP_C:    sep_q[2]   <= cfg_data;
				REG_SEP_D:    sep_q[3]   <= cfg_data;
				REG_COLLAPSE: collapse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	msft_match #(
		.NUM_SEPARATORS(NUM_SEPARATORS)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data_byte(data_s1),
		.line_end (last_s1),
		.sep      (sep_q),
		.res      (hit)
	);

	// Field end is the byte where the separator began; an overlap with the
	// previous separator leaves an empty field.
	always_comb begin
		next_pos    = {1'b0, pos_q} + (FIELD_W + 1)'(1);
		match_start = (next_pos >= (FIELD_W + 1)'(hit.hit_len))
			? next_pos - (FIELD_W + 1)'(hit.hit_len) : '0;
		len_hit     = (match_start > {1'b0, fstart_q})
			? match_start - {1'b0, fstart_q} : '0;
		len_tail    = (next_pos > {1'b0, fstart_q})
			? next_pos - {1'b0, fstart_q} : '0;
		len_sel     = hit.hit ? len_hit : len_tail;
		if (hit.hit) begin
			emit = !collapse_q || (len_hit != '0);
		end else begin
			emit = last_s1 && (len_tail != '0);
		end
		fcount_nxt = (emit && fcount_q != FIELD_MAX) ? fcount_q + FIELD_W'(1) : fcount_q;
		next_sat   = (next_pos > {1'b0, POS_LIMIT}) ? POS_LIMIT : next_pos[FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fstart_q <= '0;
			fcount_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q    <= '0;
				fstart_q <= '0;
				fcount_q <= '0;
			end else begin
				pos_q    <= next_sat;
				fcount_q <= fcount_nxt;
				if (hit.hit) begin
					fstart_q <= next_sat;
				end
			end
		end
	end

	// Result valid: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit || last_s1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fvalid_q <= emit;
			done_q   <= last_s1;
			fs_q     <= emit ? fstart_q : '0;
			fnum_q   <= emit ? fcount_q : '0;
			fin_q    <= last_s1 ? fcount_nxt : '0;
			if (!emit) begin
				fl_q <= '0;
			end else if (len_sel[FIELD_W]) begin
				fl_q <= FIELD_MAX;
			end else begin
				fl_q <= len_sel[FIELD_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = fvalid_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {fin_q, fnum_q, fl_q, fs_q};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the multi-separator field tokenizer
// Drives lines of bytes into the slave stream and keeps a software copy of
// the tokenizer that predicts every result word. Each word taken from the
// master stream is compared field by field with the oldest prediction.
// Directed lines cover the default separators, every register and stale
// match progress. Random phases then reprogram the separators and push
// random lines, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	import msft_pkg::*;

	localparam int POS_SAT       = POS_LIMIT_I;
	localparam int CNT_SAT       = 4095;
	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_LIMIT    = 4000;
	localparam int REPORT_CAP    = 200;
	localparam int PHASE_COUNT   = 10;
	localparam int PHASE_BYTES   = 200;

	// Separator length codes, bits 17:16 of a pattern register.
	localparam logic [1:0] LEN_OFF  = 2'd0;
	localparam logic [1:0] LEN_ONE  = 2'd1;
	localparam logic [1:0] LEN_TWO  = 2'd2;
	localparam logic [1:0] LEN_OVER = 2'd3;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;

	typedef struct packed {
		logic        field_valid;
		logic [11:0] field_start;
		logic [11:0] field_length;
		logic [11:0] field_number;
		logic        line_done;
		logic [11:0] fields_in_line;
	} field_word_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SEP_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [7:0] data_byte
	logic                 s_tlast   = 1'b0; // line_end
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// [11:0] field_start, [23:12] field_length, [35:24] field_number,
	// [47:36] fields_in_line
	logic [47:0]          m_tdata;
	logic                 m_tuser;          // field_valid
	logic                 m_tlast;          // line_done

	multi_separator_field_tokenizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	// Shadow copy of the tokenizer: registers and line state as after reset.
	logic [SEP_W-1:0] sep_shadow [SEP_REGS] = '{SEP_A_RST, SEP_B_RST, SEP_OFF, SEP_OFF};
	logic             collapse_shadow = 1'b1;
	logic [1:0]       progress [SEP_REGS] = '{2'd0, 2'd0, 2'd0, 2'd0};
	int               byte_pos  = 0;
	int               field_beg = 0;
	int               field_cnt = 0;

	field_word_t pending_fields [$];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int          burst_left     = 0;
	bit          gaps_on        = 1'b1;
	rx_mode_t    rx_mode        = RX_OPEN;
	int          rx_count       = 0;

	// ------------------------------------------------------------------------
	// Predictor: advance the shadow state by one byte and queue the word it
	// should produce, if any.
	// ------------------------------------------------------------------------
	task automatic tokenize_byte(input logic [7:0] b, input logic last);
		int          next, len, k, hit_len, pe, fs, fl, fnum;
		logic        hit, emit;
		logic [1:0]  code;
		logic [7:0]  pat_byte;
		field_word_t w;
		next    = byte_pos + 1;
		hit     = 1'b0;
		emit    = 1'b0;
		hit_len = 0;
		fs      = 0;
		fl      = 0;
		fnum    = 0;
		// Scan in index order; the first separator to complete wins and
		// clears every match progress, later ones are not looked at.
		for (int i = 0; i < SEP_REGS; i++) begin
			if (!hit) begin
				code = sep_shadow[i][17:16];
				len  = (code == LEN_OVER) ? int'(LEN_TWO) : int'(code);
				if (len == 0) begin
					progress[i] = 2'd0;
				end else begin
					// Progress left over from an older, longer pattern restarts.
					k = progress[i];
					if (k >= len)
						k = 0;
					pat_byte = (k == 0) ? sep_shadow[i][7:0] : sep_shadow[i][15:8];
					if (pat_byte == b) begin
						k++;
						if (k == len) begin
							hit     = 1'b1;
							hit_len = len;
							for (int j = 0; j < SEP_REGS; j++)
								progress[j] = 2'd0;
						end else begin
							progress[i] = 2'(k);
						end
					end else begin
						// No retry of this byte as a fresh start.
						progress[i] = 2'd0;
					end
				end
			end
		end

		if (hit) begin
			// A match that began at or before the field start leaves it empty.
			pe = (next >= hit_len) ? next - hit_len : 0;
			fl = (pe > field_beg) ? pe - field_beg : 0;
			if (!collapse_shadow || fl != 0) begin
				emit = 1'b1;
				fs   = field_beg;
			end
			field_beg = (next > POS_SAT) ? POS_SAT : next;
		end else if (last) begin
			fl = (next > field_beg) ? next - field_beg : 0;
			if (fl != 0) begin
				emit = 1'b1;
				fs   = field_beg;
			end
		end

		if (emit) begin
			fnum = field_cnt;
			if (field_cnt < CNT_SAT)
				field_cnt++;
		end else begin
			fs = 0;
			fl = 0;
		end

		w.field_valid    = emit;
		w.field_start    = 12'((fs > CNT_SAT) ? CNT_SAT : fs);
		w.field_length   = 12'((fl > CNT_SAT) ? CNT_SAT : fl);
		w.field_number   = 12'((fnum > CNT_SAT) ? CNT_SAT : fnum);
		w.line_done      = last;
		w.fields_in_line = last ? 12'((field_cnt > CNT_SAT) ? CNT_SAT : field_cnt) : 12'd0;
		if (emit || last)
			pending_fields.insert(pending_fields.size(), w);

		if (last) begin
			for (int j = 0; j < SEP_REGS; j++)
				progress[j] = 2'd0;
			byte_pos  = 0;
			field_beg = 0;
			field_cnt = 0;
		end else begin
			byte_pos = (next > POS_SAT) ? POS_SAT : next;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Offer one byte and hold it until the handshake; idle between bursts.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		tokenize_byte(b, last);
	endtask

	task automatic send_text(input string s, input bit closes_line);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], closes_line && i == s.len() - 1);
	endtask

	// Stop sending, wait out every predicted word, then let the input stage
	// drain bytes that produce no word.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEP_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx < SEP_REGS)
			sep_shadow[idx] = val;
		else if (idx == REG_COLLAPSE)
			collapse_shadow = val[0];
	endtask

	// Collapse flag with random upper bits, which the block must ignore.
	task automatic write_collapse(input bit on);
		logic [SEP_W-1:0] val;
		val    = SEP_W'($urandom);
		val[0] = on;
		write_reg(REG_COLLAPSE, val);
	endtask

	function automatic logic [SEP_W-1:0] pick_pattern();
		logic [7:0] alpha [8];
		logic [1:0] code;
		int         kind;
		alpha = '{",", ";", " ", "\t", ":", 8'h00, 8'hff, "a"};
		kind  = $urandom_range(0, 9);
		code  = ($urandom_range(0, 1) != 0) ? LEN_ONE : LEN_TWO;
		case (kind)
			0: return SEP_OFF;
			1: return '1;
			2: return SEP_W'($urandom_range(0, 262143));
			default: return {code, alpha[$urandom_range(0, 7)], alpha[$urandom_range(0, 7)]};
		endcase
	endfunction

	// Mostly separator bytes so that matches are frequent, then letters,
	// then anything at all.
	function automatic logic [7:0] pick_byte();
		int r, i;
		r = $urandom_range(0, 99);
		i = $urandom_range(0, SEP_REGS - 1);
		if (r < 55)
			return ($urandom_range(0, 1) != 0) ? sep_shadow[i][15:8] : sep_shadow[i][7:0];
		else if (r < 80)
			return 8'($urandom_range(97, 122));
		return 8'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset separators: tab and space with collapsing; a separator on the
	// last byte, a one-byte line and a line of nothing but a separator.
	task automatic test_default_separators();
		send_text("a\tb  c ", 1'b1);
		send_text("w", 1'b1);
		send_text(" ", 1'b1);
		wait_idle();
	endtask

	// Program every register: a two-byte pattern, a zero byte, the length
	// code that saturates, a disabled pattern with stray bytes, no collapse.
	task automatic test_all_registers();
		write_reg(REG_SEP_A, {LEN_TWO, 8'h3b, 8'h2c});
		write_reg(REG_SEP_B, {LEN_ONE, 8'h5a, 8'h00});
		write_reg(REG_SEP_C, '1);
		write_reg(REG_SEP_D, {LEN_OFF, 8'h41, 8'h41});
		write_collapse(1'b0);
		// Two-byte separator at the line start overlaps the first field.
		send_text(",;x", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("A", 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_text("z", 1'b1);
		wait_idle();
	endtask

	// Leave a half-matched two-byte pattern, shorten it, and resume.
	task automatic test_stale_progress();
		write_reg(REG_SEP_A, {LEN_TWO, 8'h3b, 8'h2c});
		write_reg(REG_SEP_B, SEP_B_RST);
		write_reg(REG_SEP_C, SEP_OFF);
		write_reg(REG_SEP_D, SEP_OFF);
		write_collapse(1'b1);
		send_text("q,", 1'b0);
		wait_idle();
		write_reg(REG_SEP_A, {LEN_ONE, 8'h3b, 8'h2c});
		send_text(",", 1'b1);
		wait_idle();
	endtask

	// Fresh random settings, then random lines; the phase may end mid-line.
	task automatic test_random_phase(input int n_bytes);
		int line_len, pos;
		for (int r = 0; r < SEP_REGS; r++)
			write_reg(CFG_IDX_W'(r), pick_pattern());
		write_collapse(1'($urandom_range(0, 1)));
		gaps_on  = ($urandom_range(0, 3) != 0);
		line_len = $urandom_range(1, 24);
		pos      = 0;
		for (int n = 0; n < n_bytes; n++) begin
			pos++;
			send_byte(pick_byte(), pos == line_len);
			if (pos == line_len) begin
				pos      = 0;
				line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
				                                       : $urandom_range(1, 24);
			end
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall pattern, word check, watchdog
	// ------------------------------------------------------------------------

	// Hold each stall mode for a random stretch; one mode never stalls.
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode  <= rx_mode_t'($urandom_range(0, 3));
			rx_count <= $urandom_range(50, 300);
		end else begin
			rx_count <= rx_count - 1;
		end
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (rx_count % 4 == 0);
			default:     m_tready <= ($urandom_range(0, 6) == 0);
		endcase
	end

	task automatic check_field(input string name, input logic [11:0] want,
	                           input logic [11:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_CAP)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : word_check
		field_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fields.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: no word expected, got tdata %h tuser %b tlast %b",
					         $time, m_tdata, m_tuser, m_tlast);
			end else begin
				want = pending_fields.pop_front();
				check_field("field_valid", 12'(want.field_valid), 12'(m_tuser));
				check_field("field_start", want.field_start, m_tdata[11:0]);
				check_field("field_length", want.field_length, m_tdata[23:12]);
				check_field("field_number", want.field_number, m_tdata[35:24]);
				check_field("line_done", 12'(want.line_done), 12'(m_tlast));
				check_field("fields_in_line", want.fields_in_line, m_tdata[47:36]);
			end
		end
	end

	// Drop out if neither stream moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_separators();
		test_all_registers();
		test_stale_progress();
		for (int p = 0; p < PHASE_COUNT; p++)
			test_random_phase(PHASE_BYTES);

		wait_idle();
		if (mismatch_count == 0 && pending_fields.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== multi_separator_field_tokenizer_unit.f =====
sv/msft_pkg.sv
sv/msft_match.sv
sv/multi_separator_field_tokenizer_unit.sv
test/tb.sv
